// ===== design/rcrs_pkg.sv =====
`default_nettype none
package rcrs_pkg;

  localparam int FracBits    = 12;
  localparam int MapCellBits = 8;
  localparam int ColumnBits  = 12;
  localparam int WidthBits   = 13;
  localparam int WidthReset  = 640;
  localparam int DirBits     = 16;
  localparam int WideBits    = 20;

  // Front record: one classified column and its axis inputs.
  typedef struct packed {
    logic [WidthBits-1:0] width;
    logic [WidthBits-1:0] span;
    logic [19:0]          pos_x;
    logic [19:0]          pos_y;
    logic [7:0]           cell_x;
    logic [7:0]           cell_y;
    logic signed [15:0]   look_x;
    logic signed [15:0]   look_y;
    logic signed [15:0]   plane_x;
    logic signed [15:0]   plane_y;
  } front_t;

  // Per-axis carry record through the back pipeline.
  typedef struct packed {
    logic [19:0] pos;
    logic [7:0]  cell_idx;
  } axis_t;

  // Signed 16-bit saturation of an 18-bit sum.
  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) r = 16'sh7fff;
    else if (v < -18'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/rcrs_div.sv =====
`default_nettype none
// Pipelined restoring divider: one quotient bit per stage, so a new
// division may enter every cycle while en_i is high. Carries a tag alongside.
module rcrs_div #(
  parameter int NumBits = 26,
  parameter int DenBits = 16,
  parameter int TagBits = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               vld_i,
  input  wire logic [NumBits-1:0] num_i,
  input  wire logic [DenBits-1:0] den_i,
  input  wire logic [TagBits-1:0] tag_i,
  output logic                    vld_o,
  output logic [NumBits-1:0]      quo_o,
  output logic [TagBits-1:0]      tag_o
);

  logic [NumBits:0]                vld_q;
  logic [NumBits-1:0]              num_q [NumBits+1];
  logic [DenBits-1:0]              rem_q [NumBits+1];
  logic [DenBits-1:0]              den_q [NumBits+1];
  logic [TagBits-1:0]              tag_q [NumBits+1];

  always_comb begin
    num_q[0] = num_i;
    rem_q[0] = '0;
    den_q[0] = den_i;
    tag_q[0] = tag_i;
    vld_q[0] = vld_i;
  end

  // One stage a quotient bit, shifted in at the bottom of the numerator word.
  for (genvar s = 0; s < NumBits; s++) begin : g_stage
    logic [DenBits:0] trial;
    logic             ge;
    assign trial = {rem_q[s], num_q[s][NumBits-1]};
    assign ge    = trial >= {1'b0, den_q[s]};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1] <= ge ? DenBits'(trial - {1'b0, den_q[s]}) : trial[DenBits-1:0];
        num_q[s+1] <= {num_q[s][NumBits-2:0], ge};
        den_q[s+1] <= den_q[s];
        tag_q[s+1] <= tag_q[s];
      end
    end
  end

  assign vld_o = vld_q[NumBits];
  assign quo_o = num_q[NumBits];
  assign tag_o = tag_q[NumBits];

endmodule
`default_nettype wire

// ===== design/rcrs_front.sv =====
`default_nettype none
// Front: takes items, clamps the column, and pushes a record into a
// two-entry queue that parts it from the back pipeline.
module rcrs_front (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [12:0]           width_i,
  input  wire logic                  in_vld_i,
  output logic                       in_rdy_o,
  input  wire logic [11:0]           column_i,
  input  wire logic [19:0]           pos_x_i,
  input  wire logic [19:0]           pos_y_i,
  input  wire logic [7:0]            cell_x_i,
  input  wire logic [7:0]            cell_y_i,
  input  wire logic signed [15:0]    look_x_i,
  input  wire logic signed [15:0]    look_y_i,
  input  wire logic signed [15:0]    plane_x_i,
  input  wire logic signed [15:0]    plane_y_i,
  output logic                       vld_o,
  input  wire logic                  rdy_i,
  output rcrs_pkg::front_t           rec_o
);

  rcrs_pkg::front_t rec_d;
  rcrs_pkg::front_t mem_q [2];
  logic             wp_q, rp_q;
  logic [1:0]       cnt_q;
  logic [12:0]      w;
  logic [12:0]      col;
  logic             push, pop;

  // Zero width acts as one; a column past the width is clamped to it.
  always_comb begin
    w   = (width_i == '0) ? 13'd1 : width_i;
    col = ({1'b0, column_i} > w) ? w : {1'b0, column_i};
    rec_d.width   = w;
    rec_d.span    = w - col;
    rec_d.pos_x   = pos_x_i;
    rec_d.pos_y   = pos_y_i;
    rec_d.cell_x  = cell_x_i;
    rec_d.cell_y  = cell_y_i;
    rec_d.look_x  = look_x_i;
    rec_d.look_y  = look_y_i;
    rec_d.plane_x = plane_x_i;
    rec_d.plane_y = plane_y_i;
  end

  assign in_rdy_o = cnt_q != 2'd2;
  assign vld_o    = cnt_q != 2'd0;
  assign push     = in_vld_i && in_rdy_o;
  assign pop      = vld_o && rdy_i;
  assign rec_o    = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= rec_d;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("front queue overfilled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q != 2'd0)
    else $error("front queue lost an item");
  assert property (@(posedge clk_i) disable iff (!rst_ni) vld_o |-> rec_o.span <= rec_o.width)
    else $error("column not clamped");

endmodule
`default_nettype wire

// ===== design/rcrs_back.sv =====
`default_nettype none
// Back: camera divide, ray multiply, reciprocal divides, side multiply.
// The whole pipeline advances together; it stalls only when the output
// register is full and not taken.
module rcrs_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             vld_i,
  output logic                  rdy_o,
  input  rcrs_pkg::front_t      rec_i,
  output logic                  vld_o,
  input  wire logic             rdy_i,
  output logic signed [15:0]    ray_x_o,
  output logic signed [15:0]    ray_y_o,
  output logic [19:0]           delta_x_o,
  output logic [19:0]           delta_y_o,
  output logic [1:0]            step_x_o,
  output logic [1:0]            step_y_o,
  output logic [19:0]           side_x_o,
  output logic [19:0]           side_y_o
);

  localparam int CamTag = 2*(20+8) + 4*16;
  localparam int RcpTag = 20+8+16+1;

  logic en;
  logic out_vld_q;
  assign en    = !out_vld_q || rdy_i;
  assign rdy_o = en;

  // Camera: floor(2*span*2^F / W); 26-bit numerator.
  logic             cv;
  logic [25:0]      cq;
  logic [CamTag-1:0] ct;
  rcrs_div #(.NumBits(26), .DenBits(13), .TagBits(CamTag)) u_cam (
    .clk_i, .rst_ni, .en_i(en), .vld_i(vld_i),
    .num_i({rec_i.span, 13'd0}),
    .den_i(rec_i.width),
    .tag_i({rec_i.pos_x, rec_i.cell_x, rec_i.pos_y, rec_i.cell_y,
            rec_i.look_x, rec_i.look_y, rec_i.plane_x, rec_i.plane_y}),
    .vld_o(cv), .quo_o(cq), .tag_o(ct));

  // Multiply plane by camera and register the products.
  logic signed [14:0] cam;
  logic               m_vld_q;
  logic signed [30:0] prx_q, pry_q;
  logic signed [15:0] lkx_q, lky_q;
  rcrs_pkg::axis_t    ax_q, ay_q;
  assign cam = $signed({1'b0, cq[13:0]}) - 15'sd4096;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_vld_q <= 1'b0;
    else if (en) m_vld_q <= cv;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      prx_q <= $signed(ct[31:16]) * cam;
      pry_q <= $signed(ct[15:0]) * cam;
      lkx_q <= $signed(ct[63:48]);
      lky_q <= $signed(ct[47:32]);
      ax_q  <= ct[CamTag-1 -: 28];
      ay_q  <= ct[CamTag-29 -: 28];
    end
  end

  // Arithmetic shift floors; add look and saturate.
  logic signed [15:0] rx, ry;
  logic [15:0]        mx, my;
  assign rx = rcrs_pkg::sat16(18'(lkx_q) + 18'(prx_q >>> 12));
  assign ry = rcrs_pkg::sat16(18'(lky_q) + 18'(pry_q >>> 12));
  assign mx = rx[15] ? 16'(-rx) : rx;
  assign my = ry[15] ? 16'(-ry) : ry;

  // Reciprocals 2^24 / |ray|, computed as 25-bit quotients.
  logic rvx, rvy;
  logic [24:0] qx, qy;
  logic [RcpTag-1:0] tx, ty;
  rcrs_div #(.NumBits(25), .DenBits(16), .TagBits(RcpTag)) u_rx (
    .clk_i, .rst_ni, .en_i(en), .vld_i(m_vld_q),
    .num_i(25'h1000000), .den_i(mx),
    .tag_i({ax_q, rx, 1'b0}), .vld_o(rvx), .quo_o(qx), .tag_o(tx));
  rcrs_div #(.NumBits(25), .DenBits(16), .TagBits(RcpTag)) u_ry (
    .clk_i, .rst_ni, .en_i(en), .vld_i(m_vld_q),
    .num_i(25'h1000000), .den_i(my),
    .tag_i({ay_q, ry, 1'b0}), .vld_o(rvy), .quo_o(qy), .tag_o(ty));

  // Delta with zero and range saturation, distance to first grid line.
  function automatic logic [19:0] delta_of(input logic [24:0] q, input logic [15:0] r);
    logic [19:0] d;
    if (r == '0 || q > 25'hfffff) d = 20'hfffff;
    else d = q[19:0];
    return d;
  endfunction
  function automatic logic [20:0] dist_of(input logic [RcpTag-1:0] t);
    logic [19:0] pos;
    logic [20:0] base, top;
    logic [20:0] d;
    pos  = t[RcpTag-1 -: 20];
    base = {1'b0, t[RcpTag-21 -: 8], 12'd0};
    top  = base + 21'd4096;
    if (t[16]) d = ({1'b0, pos} >= base) ? {1'b0, pos} - base : '0;
    else d = (top >= {1'b0, pos}) ? top - {1'b0, pos} : '0;
    return d;
  endfunction

  logic        s_vld_q;
  logic [19:0] dx_q, dy_q;
  logic [20:0] sx_q, sy_q;
  logic signed [15:0] rx2_q, ry2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s_vld_q <= 1'b0;
    else if (en) s_vld_q <= rvx & rvy;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q  <= delta_of(qx, tx[16:1]);
      dy_q  <= delta_of(qy, ty[16:1]);
      sx_q  <= dist_of(tx);
      sy_q  <= dist_of(ty);
      rx2_q <= $signed(tx[16:1]);
      ry2_q <= $signed(ty[16:1]);
    end
  end

  // Side product, then truncate and saturate into the output register.
  logic [40:0] px, py;
  assign px = sx_q * dx_q;
  assign py = sy_q * dy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (en) out_vld_q <= s_vld_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      ray_x_o   <= rx2_q;
      ray_y_o   <= ry2_q;
      delta_x_o <= dx_q;
      delta_y_o <= dy_q;
      step_x_o  <= rx2_q[15] ? 2'b11 : 2'b01;
      step_y_o  <= ry2_q[15] ? 2'b11 : 2'b01;
      side_x_o  <= (px[40:12] > 29'hfffff) ? 20'hfffff : px[31:12];
      side_y_o  <= (py[40:12] > 29'hfffff) ? 20'hfffff : py[31:12];
    end
  end
  assign vld_o = out_vld_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) rvx == rvy)
    else $error("reciprocal lanes out of step");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_o && !rdy_i) |=> vld_o)
    else $error("output item dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_o |-> (step_x_o == 2'b01 || step_x_o == 2'b11))
    else $error("bad step code");

endmodule
`default_nettype wire

// ===== design/raycast_column_ray_setup.sv =====
`default_nettype none
// Per-column ray setup for a grid raycaster. One item enters per cycle and
// one result leaves per cycle unless the output stalls. A result passes the
// bit-per-stage camera divider (26 stages), the multiply registers, the
// reciprocal dividers (25 stages), and the delta and output registers. A
// two-entry queue parts the input side from the pipeline. screen_width may
// be written only when idle.
module raycast_column_ray_setup (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [12:0]   cfg_wdata_i,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  // column[11:0], view_pos_x[31:12], view_pos_y[51:32], cell_x[59:52],
  // cell_y[67:60], look_x[83:68], look_y[99:84], plane_x[115:100],
  // plane_y[131:116], zero fill to 136
  input  wire logic [135:0]  s_axis_tdata,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // ray_x[15:0], ray_y[31:16], delta_x[51:32], delta_y[71:52],
  // step_x[73:72], step_y[75:74], side_x[95:76], side_y[115:96], zero to 120
  output logic [119:0]       m_axis_tdata
);

  logic [12:0] width_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) width_q <= 13'(rcrs_pkg::WidthReset);
    else if (cfg_we_i) width_q <= cfg_wdata_i;
  end

  logic             fv, fr;
  rcrs_pkg::front_t rec;
  rcrs_front u_front (
    .clk_i, .rst_ni, .width_i(width_q),
    .in_vld_i(s_axis_tvalid), .in_rdy_o(s_axis_tready),
    .column_i(s_axis_tdata[11:0]), .pos_x_i(s_axis_tdata[31:12]),
    .pos_y_i(s_axis_tdata[51:32]), .cell_x_i(s_axis_tdata[59:52]),
    .cell_y_i(s_axis_tdata[67:60]), .look_x_i(s_axis_tdata[83:68]),
    .look_y_i(s_axis_tdata[99:84]), .plane_x_i(s_axis_tdata[115:100]),
    .plane_y_i(s_axis_tdata[131:116]),
    .vld_o(fv), .rdy_i(fr), .rec_o(rec));

  logic signed [15:0] rx, ry;
  logic [19:0] dx, dy, sx, sy;
  logic [1:0]  stx, sty;
  rcrs_back u_back (
    .clk_i, .rst_ni, .vld_i(fv), .rdy_o(fr), .rec_i(rec),
    .vld_o(m_axis_tvalid), .rdy_i(m_axis_tready),
    .ray_x_o(rx), .ray_y_o(ry), .delta_x_o(dx), .delta_y_o(dy),
    .step_x_o(stx), .step_y_o(sty), .side_x_o(sx), .side_y_o(sy));

  assign m_axis_tdata = {4'd0, sy, sx, sty, stx, dy, dx, ry, rx};

endmodule
`default_nettype wire
